[hdl/cht_pkg.sv]
package cht_pkg;

    localparam int MAX_BUCKETS_DEF = 256;
    localparam int POOL_DEPTH_DEF  = 1024;

    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int BUCKET_W = 8;
    localparam int COUNT_W  = 11;
    localparam int BCNT_W   = 9;
    localparam int STATUS_W = 3;

    localparam logic [BCNT_W-1:0] BUCKET_COUNT_RST = 9'd256;

    typedef enum logic [STATUS_W-1:0] {
        ST_NOT_FOUND,
        ST_FOUND,
        ST_UPDATED,
        ST_CREATED,
        ST_POOL_FULL,
        ST_BAD_BUCKET
    } t_status;

    typedef struct packed {
        logic clr_en;
        logic load;
        logic rd_head;
        logic rd_node;
        logic from_link;
        logic fin_bad;
        logic fin_hit;
        logic fin_miss;
        logic present;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic in_bad;
        logic ref_null;
        logic match;
        logic out_free;
    } t_sts;

endpackage

[hdl/cht_ram.sv]
module cht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/cht_ctrl.sv]
module cht_ctrl
    import cht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_ready
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HEAD,
        S_NODE,
        S_RESP
    } t_state;

    t_state r_state, n_state;
    logic   r_ready;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid && r_ready) begin
                    cmd.load = 1'b1;
                    if (i_sts.in_bad) begin
                        cmd.fin_bad = 1'b1;
                        n_state     = S_RESP;
                    end else begin
                        cmd.rd_head = 1'b1;
                        n_state     = S_HEAD;
                    end
                end
            end
            S_HEAD: begin
                if (i_sts.ref_null) begin
                    cmd.fin_miss = 1'b1;
                    n_state      = S_RESP;
                end else begin
                    cmd.rd_node = 1'b1;
                    n_state     = S_NODE;
                end
            end
            S_NODE: begin
                cmd.from_link = 1'b1;
                if (i_sts.match) begin
                    cmd.fin_hit = 1'b1;
                    n_state     = S_RESP;
                end else if (i_sts.ref_null) begin
                    cmd.fin_miss = 1'b1;
                    n_state      = S_RESP;
                end else begin
                    cmd.rd_node = 1'b1;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    cmd.present = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_cmd      = cmd;
    assign o_in_ready = r_ready;

endmodule

[hdl/cht_dp.sv]
module cht_dp
    import cht_pkg::*;
#(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int POOL_DEPTH  = POOL_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [BCNT_W-1:0]         i_cfg_wr_data,
    input  logic                      i_req_type,
    input  logic signed [KEY_W-1:0]   i_key,
    input  logic signed [VALUE_W-1:0] i_value_in,
    input  logic [BUCKET_W-1:0]       i_bucket,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output t_status                   o_status,
    output logic signed [VALUE_W-1:0] o_value_out,
    output logic [COUNT_W-1:0]        o_entry_count
);

    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int NW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int RW = $clog2(POOL_DEPTH + 1);

    logic [BCNT_W-1:0]         r_bucket_count;
    logic [RW-1:0]             r_count;
    logic [BW-1:0]             r_clr;
    logic                      r_req;
    logic signed [KEY_W-1:0]   r_key;
    logic signed [VALUE_W-1:0] r_value;
    logic [BW-1:0]             r_bidx;
    logic [NW-1:0]             r_node;
    logic [RW-1:0]             r_head;
    t_status                   r_res_status;
    logic signed [VALUE_W-1:0] r_res_value;
    logic                      r_out_valid;
    t_status                   r_out_status;
    logic signed [VALUE_W-1:0] r_out_value;
    logic [COUNT_W-1:0]        r_out_count;

    logic [RW-1:0]      head_rdata;
    logic [RW-1:0]      link_rdata;
    logic [KEY_W-1:0]   key_rdata;
    logic [VALUE_W-1:0] val_rdata;
    logic [RW-1:0]      cur_ref;
    logic [NW-1:0]      next_node;
    logic [RW-1:0]      link_head;
    logic               pool_full;
    logic               create;
    logic               update;
    logic               out_free;

    logic               head_we;
    logic [BW-1:0]      head_waddr;
    logic [RW-1:0]      head_wdata;
    logic               val_we;
    logic [NW-1:0]      val_waddr;

    assign cur_ref   = i_cmd.from_link ? link_rdata : head_rdata;
    assign next_node = NW'(cur_ref - RW'(1));
    assign link_head = i_cmd.from_link ? r_head : head_rdata;
    assign pool_full = (r_count == RW'(POOL_DEPTH));
    assign create    = i_cmd.fin_miss && r_req && !pool_full;
    assign update    = i_cmd.fin_hit && r_req;
    assign out_free  = !r_out_valid || i_out_ready;

    assign head_we    = i_cmd.clr_en || create;
    assign head_waddr = i_cmd.clr_en ? r_clr : r_bidx;
    assign head_wdata = i_cmd.clr_en ? '0 : RW'(r_count + RW'(1));
    assign val_we     = create || update;
    assign val_waddr  = update ? r_node : NW'(r_count);

    assign o_sts.clr_last = (r_clr == BW'(MAX_BUCKETS - 1));
    assign o_sts.in_bad   = ({1'b0, i_bucket} >= r_bucket_count)
                         || ({24'd0, i_bucket} >= 32'(MAX_BUCKETS));
    assign o_sts.ref_null = (cur_ref == '0);
    assign o_sts.match    = (key_rdata == r_key);
    assign o_sts.out_free = out_free;

    cht_ram #(.WIDTH(RW), .DEPTH(MAX_BUCKETS)) u_heads (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (head_wdata),
        .i_re    (i_cmd.rd_head),
        .i_raddr (BW'(i_bucket)),
        .o_rdata (head_rdata)
    );

    cht_ram #(.WIDTH(KEY_W), .DEPTH(POOL_DEPTH)) u_keys (
        .i_clk   (i_clk),
        .i_we    (create),
        .i_waddr (NW'(r_count)),
        .i_wdata (r_key),
        .i_re    (i_cmd.rd_node),
        .i_raddr (next_node),
        .o_rdata (key_rdata)
    );

    cht_ram #(.WIDTH(VALUE_W), .DEPTH(POOL_DEPTH)) u_values (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (r_value),
        .i_re    (i_cmd.rd_node),
        .i_raddr (next_node),
        .o_rdata (val_rdata)
    );

    cht_ram #(.WIDTH(RW), .DEPTH(POOL_DEPTH)) u_links (
        .i_clk   (i_clk),
        .i_we    (create),
        .i_waddr (NW'(r_count)),
        .i_wdata (link_head),
        .i_re    (i_cmd.rd_node),
        .i_raddr (next_node),
        .o_rdata (link_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= BUCKET_COUNT_RST;
            r_count        <= '0;
            r_clr          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_bucket_count <= i_cfg_wr_data;
            end
            if (i_cmd.clr_en) begin
                r_clr <= r_clr + BW'(1);
            end
            if (create) begin
                r_count <= r_count + RW'(1);
            end
            if (i_cmd.present) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_req_type;
            r_key   <= i_key;
            r_value <= i_value_in;
            r_bidx  <= BW'(i_bucket);
        end
        if (i_cmd.rd_node) begin
            r_node <= next_node;
        end
        if (i_cmd.rd_node && !i_cmd.from_link) begin
            r_head <= head_rdata;
        end
        if (i_cmd.fin_bad) begin
            r_res_status <= ST_BAD_BUCKET;
            r_res_value  <= '0;
        end
        if (i_cmd.fin_hit) begin
            r_res_status <= r_req ? ST_UPDATED : ST_FOUND;
            r_res_value  <= r_req ? '0 : val_rdata;
        end
        if (i_cmd.fin_miss) begin
            if (!r_req) begin
                r_res_status <= ST_NOT_FOUND;
            end else if (pool_full) begin
                r_res_status <= ST_POOL_FULL;
            end else begin
                r_res_status <= ST_CREATED;
            end
            r_res_value <= '0;
        end
        if (i_cmd.present) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
            r_out_count  <= COUNT_W'(r_count);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_value_out   = r_out_value;
    assign o_entry_count = r_out_count;

endmodule

[hdl/chained_hash_table_engine.sv]
// Key/value table with separate chaining; the caller picks the bucket. After reset the
// bucket heads are cleared in a pass over all MAX_BUCKETS heads, while no item is taken.
// An accepted item reads its bucket head, then visits chain nodes in turn until a key
// matches or the chain ends (no node for an empty chain, up to the chain length on a
// miss); a bad bucket skips both reads. The next item is accepted only once the result
// has moved to the output register. The walk visits one node per cycle through the
// registered read port of the node memories. A finished result waits in an output
// register while the next item is accepted; a result that the sink has not yet taken
// holds the following one back until the register frees.
module chained_hash_table_engine
    import cht_pkg::*;
#(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int POOL_DEPTH  = POOL_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [BCNT_W-1:0] i_cfg_wr_data,   // bucket_count
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [71:0]       i_s_axis_tdata,  // key, value_in, bucket
    input  logic [0:0]        i_s_axis_tuser,  // req_type
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [47:0]       o_m_axis_tdata,  // value_out, entry_count, zero pad
    output logic [2:0]        o_m_axis_tuser   // status
);

    t_cmd                      cmd;
    t_sts                      sts;
    t_status                   status;
    logic signed [VALUE_W-1:0] value_out;
    logic [COUNT_W-1:0]        entry_count;

    cht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (o_s_axis_tready)
    );

    cht_dp #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .POOL_DEPTH  (POOL_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req_type    (i_s_axis_tuser[0]),
        .i_key         (i_s_axis_tdata[31:0]),
        .i_value_in    (i_s_axis_tdata[63:32]),
        .i_bucket      (i_s_axis_tdata[71:64]),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_status      (status),
        .o_value_out   (value_out),
        .o_entry_count (entry_count)
    );

    assign o_m_axis_tdata = {5'd0, entry_count, value_out};
    assign o_m_axis_tuser = status;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input still ready after an item was taken");

    a_value_only_on_find: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (status != ST_FOUND)) |-> (value_out == '0))
        else $error("non-zero value on a result other than found");

    a_created_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (status == ST_CREATED)) |-> (entry_count != '0))
        else $error("created result with an empty table");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (32'(entry_count) <= POOL_DEPTH))
        else $error("entry count beyond pool depth");

endmodule

[bench/chained_hash_table_engine_test.sv]
`timescale 1ns / 1ps

module chained_hash_table_engine_test;
    import cht_pkg::*;

    localparam int NODES   = POOL_DEPTH_DEF;
    localparam int BUCKETS = MAX_BUCKETS_DEF;
    localparam int NODE_AW = $clog2(NODES);

    typedef struct packed {
        logic                req;
        logic [KEY_W-1:0]    key;
        logic [VALUE_W-1:0]  val;
        logic [BUCKET_W-1:0] bucket;
    } t_table_req;

    typedef struct packed {
        t_status             status;
        logic [VALUE_W-1:0]  value;
        logic [COUNT_W-1:0]  entries;
    } t_table_res;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [BCNT_W-1:0]   cfg_wr_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [71:0]         s_tdata = '0;
    logic [0:0]          s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [47:0]         m_tdata;
    logic [2:0]          m_tuser;

    t_table_req          pending_reqs[$];
    t_table_res          awaited_results[$];

    logic [COUNT_W-1:0]  chain_head[BUCKETS];
    logic [KEY_W-1:0]    node_key[NODES];
    logic [VALUE_W-1:0]  node_val[NODES];
    logic [COUNT_W-1:0]  node_link[NODES];
    logic [COUNT_W-1:0]  used_nodes;
    logic [BCNT_W-1:0]   bucket_limit;

    logic [KEY_W-1:0]    key_pool[64];
    int                  src_idle_pct = 0;
    int                  snk_stall_pct = 0;
    int                  mismatches = 0;
    int                  reqs_sent = 0;
    int                  results_seen = 0;
    int                  settings_used = 0;
    int                  status_seen[6];

    chained_hash_table_engine dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_table_res apply_request(t_table_req r);
        t_table_res  res;
        logic [COUNT_W-1:0] ref_no;
        int          steps;
        bit          hit;
        res.status  = ST_NOT_FOUND;
        res.value   = '0;
        if ({1'b0, r.bucket} >= bucket_limit) begin
            res.status = ST_BAD_BUCKET;
        end else begin
            ref_no = chain_head[r.bucket];
            steps  = 0;
            hit    = 1'b0;
            while (!hit && ref_no != 0 && steps < NODES) begin
                if (node_key[NODE_AW'(ref_no - 1'b1)] == r.key) begin
                    hit = 1'b1;
                end else begin
                    ref_no = node_link[NODE_AW'(ref_no - 1'b1)];
                    steps++;
                end
            end
            if (!r.req) begin
                if (hit) begin
                    res.status = ST_FOUND;
                    res.value  = node_val[NODE_AW'(ref_no - 1'b1)];
                end
            end else if (hit) begin
                node_val[NODE_AW'(ref_no - 1'b1)] = r.val;
                res.status = ST_UPDATED;
            end else if (used_nodes >= NODES) begin
                res.status = ST_POOL_FULL;
            end else begin
                node_key[NODE_AW'(used_nodes)]  = r.key;
                node_val[NODE_AW'(used_nodes)]  = r.val;
                node_link[NODE_AW'(used_nodes)] = chain_head[r.bucket];
                chain_head[r.bucket]  = used_nodes + 1'b1;
                used_nodes            = used_nodes + 1'b1;
                res.status = ST_CREATED;
            end
        end
        res.entries = used_nodes;
        return res;
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) begin
            $display("MISMATCH at %0t: %s", $realtime, what);
        end
    endtask

    always @(posedge i_clk) begin
        logic nxt_valid;
        if (s_tvalid && s_tready) begin
            awaited_results.push_back(apply_request(pending_reqs[0]));
            void'(pending_reqs.pop_front());
            reqs_sent++;
        end
        nxt_valid = 1'b0;
        if (i_rst_n && pending_reqs.size() > 0) begin
            if (s_tvalid && !s_tready) begin
                nxt_valid = 1'b1;
            end else begin
                nxt_valid = ($urandom_range(99, 0) >= src_idle_pct);
            end
        end
        s_tvalid <= nxt_valid;
        if (nxt_valid) begin
            s_tdata <= {pending_reqs[0].bucket, pending_reqs[0].val, pending_reqs[0].key};
            s_tuser <= pending_reqs[0].req;
        end
    end

    always @(posedge i_clk) begin
        t_table_res want;
        logic [VALUE_W-1:0] got_value;
        logic [COUNT_W-1:0] got_entries;
        if (m_tvalid && m_tready) begin
            got_value   = m_tdata[31:0];
            got_entries = m_tdata[42:32];
            results_seen++;
            if (m_tuser < 6) begin
                status_seen[m_tuser]++;
            end
            if (awaited_results.size() == 0) begin
                note_mismatch($sformatf("unexpected result status %0d value %h entries %0d",
                                        m_tuser, got_value, got_entries));
            end else begin
                want = awaited_results.pop_front();
                if (m_tuser != want.status || got_value != want.value ||
                    got_entries != want.entries) begin
                    note_mismatch($sformatf(
                        "status %0d/%0d value %h/%h entries %0d/%0d (expected/actual)",
                        want.status, m_tuser, want.value, got_value,
                        want.entries, got_entries));
                end
            end
        end
        m_tready <= ($urandom_range(99, 0) >= snk_stall_pct);
    end

    task automatic write_bucket_count(input int n);
        @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n[BCNT_W-1:0];
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        bucket_limit = n[BCNT_W-1:0];
        settings_used++;
    endtask

    task automatic push_req(input logic rt, input logic [31:0] k, input logic [31:0] v,
                            input logic [7:0] b);
        t_table_req r;
        r.req    = rt;
        r.key    = k;
        r.val    = v;
        r.bucket = b;
        pending_reqs.push_back(r);
    endtask

    task automatic fill_random(input int n, input int find_pct, input int newkey_pct,
                               input int bad_pct, input int span);
        t_table_req r;
        int lim;
        for (int i = 0; i < n; i++) begin
            r.req = ($urandom_range(99, 0) >= find_pct);
            r.key = ($urandom_range(99, 0) < newkey_pct) ? $urandom()
                                                         : key_pool[$urandom_range(63, 0)];
            r.val = $urandom();
            lim   = (bucket_limit < span) ? bucket_limit : span;
            if (lim == 0 || (bucket_limit < BUCKETS && $urandom_range(99, 0) < bad_pct)) begin
                r.bucket = BUCKET_W'($urandom_range(BUCKETS - 1, (bucket_limit < BUCKETS) ?
                                                    bucket_limit : 0));
            end else begin
                r.bucket = BUCKET_W'($urandom_range(lim - 1, 0));
            end
            pending_reqs.push_back(r);
        end
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_idling(input int src, input int snk);
        src_idle_pct  = src;
        snk_stall_pct = snk;
    endtask

    initial begin
        for (int b = 0; b < BUCKETS; b++) begin
            chain_head[b] = '0;
        end
        for (int n = 0; n < NODES; n++) begin
            node_key[n]  = '0;
            node_val[n]  = '0;
            node_link[n] = '0;
        end
        for (int s = 0; s < 6; s++) begin
            status_seen[s] = 0;
        end
        used_nodes   = '0;
        bucket_limit = BUCKET_COUNT_RST;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < 64; i++) begin
            key_pool[i] = $urandom();
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_bucket_count(256);
        set_idling(0, 0);
        push_req(1'b0, 32'h0000_0000, 32'hffff_ffff, 8'd0);
        push_req(1'b1, 32'h8000_0000, 32'h7fff_ffff, 8'd0);
        push_req(1'b1, 32'h7fff_ffff, 32'h8000_0000, 8'd0);
        push_req(1'b0, 32'h8000_0000, 32'h0000_0000, 8'd0);
        push_req(1'b0, 32'h7fff_ffff, 32'h1234_5678, 8'd0);
        push_req(1'b0, 32'h0000_0000, 32'h0000_0000, 8'd0);
        push_req(1'b1, 32'h8000_0000, 32'h0000_0000, 8'd0);
        push_req(1'b0, 32'h8000_0000, 32'h0000_0000, 8'd0);
        push_req(1'b1, 32'hffff_ffff, 32'hffff_ffff, 8'd255);
        push_req(1'b0, 32'hffff_ffff, 32'h0000_0000, 8'd255);
        push_req(1'b0, 32'h0000_0000, 32'h0000_0000, 8'd255);
        push_req(1'b1, 32'h0000_0000, 32'h0000_0001, 8'd128);
        push_req(1'b1, 32'h0000_0000, 32'hfedc_ba98, 8'd128);
        push_req(1'b0, 32'h0000_0000, 32'h0000_0000, 8'd128);
        push_req(1'b0, 32'h0000_0000, 32'h0000_0000, 8'd127);
        drain();

        write_bucket_count(1);
        push_req(1'b0, 32'hffff_ffff, 32'h0000_0000, 8'd255);
        push_req(1'b1, 32'h0000_0000, 32'h0000_0005, 8'd1);
        push_req(1'b0, 32'h0000_0000, 32'h0000_0000, 8'd128);
        push_req(1'b0, 32'h7fff_ffff, 32'h0000_0000, 8'd0);
        push_req(1'b1, 32'h0000_0000, 32'haaaa_5555, 8'd0);
        push_req(1'b0, 32'h0000_0000, 32'h0000_0000, 8'd0);
        drain();

        set_idling(64, 0);
        fill_random(250, 45, 20, 25, BUCKETS);
        drain();

        write_bucket_count(37);
        set_idling(0, 64);
        fill_random(350, 40, 40, 15, 37);
        drain();

        write_bucket_count(256);
        set_idling(30, 30);
        push_req(1'b0, 32'hffff_ffff, 32'h0000_0000, 8'd255);
        push_req(1'b0, 32'h0000_0000, 32'h0000_0000, 8'd128);
        fill_random(650, 15, 95, 0, BUCKETS);
        drain();

        write_bucket_count(0);
        set_idling(0, 0);
        fill_random(20, 50, 50, 100, BUCKETS);
        drain();

        write_bucket_count(128);
        set_idling(64, 0);
        fill_random(550, 40, 60, 10, 128);
        drain();

        set_idling(0, 0);
        repeat (1100) @(posedge i_clk);
        while (awaited_results.size() != 0) begin
            void'(awaited_results.pop_front());
            note_mismatch("result never arrived");
        end

        $display("Sent %0d requests under %0d bucket-count settings, %0d results checked.",
                 reqs_sent, settings_used, results_seen);
        $display("Statuses: miss %0d, found %0d, updated %0d, created %0d, full %0d, bad %0d.",
                 status_seen[0], status_seen[1], status_seen[2],
                 status_seen[3], status_seen[4], status_seen[5]);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Mismatches: %0d", mismatches);
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Timeout with %0d requests pending and %0d results awaited",
                 pending_reqs.size(), awaited_results.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
